// ===== rtl/tapu_pkg.sv =====
`default_nettype none
package tapu_pkg;

    localparam int NODE_BITS = 8;
    localparam int NODE_COUNT = 1 << NODE_BITS;
    localparam int CELL_BITS = 2 * NODE_BITS;
    localparam logic [15:0] NO_PATH = 16'hFFFF;
    localparam logic [15:0] CAP = 16'hFFFE;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_CHG = 2'd1;
    localparam logic [1:0] MARK_REACH = 2'd2;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] instant;
        logic [7:0]  first_node;
        logic [7:0]  second_node;
    } t_in;

    typedef struct packed {
        logic [15:0] latency;
        logic [15:0] hop_count;
        logic        changed_now;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OUT,
        S_SWEEP,
        S_SWEEP_END,
        S_DIRECT,
        S_WALK,
        S_DRAIN
    } t_state;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CAP}) ? CAP : s[15:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tapu_ram.sv =====
`default_nettype none
module tapu_ram #(
    parameter int DW = 32,
    parameter int AW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/temporal_all_pairs_path_update.sv =====
// A read passes through S_OUT, which waits while the output stalls, to a registered result;
// no new transaction is taken until S_IDLE. An edge within the open instant runs one row
// walk per direction; an edge that opens a new instant first sweeps the whole matrix.
// After reset the block clears every cell of its memories before it accepts a
// transaction; configuration writes are taken throughout.
`default_nettype none
module temporal_all_pairs_path_update
    import tapu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata
);

    t_state r_state, n_state;
    logic [CELL_BITS-1:0] r_cnt, n_cnt;
    logic r_p_vld, n_p_vld;
    logic [CELL_BITS-1:0] r_p_addr, n_p_addr;
    logic r_undir;
    logic r_open, n_open;
    logic r_commit, n_commit;
    logic [15:0] r_cur, n_cur;
    logic [15:0] r_inst, n_inst;
    logic [15:0] r_delay, n_delay;
    logic [NODE_BITS-1:0] r_row, n_row, r_via, n_via;
    logic r_pass, n_pass;
    logic r_rd_ok, n_rd_ok;
    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;

    logic cm_we, wk_we, mk_we, cm_re, wk_re, mk_re;
    logic [CELL_BITS-1:0] cm_wa, wk_wa, mk_wa, cm_ra, wk_ra, mk_ra;
    logic [31:0] cm_wd, wk_wd, cm_rd, wk_rd;
    logic [1:0] mk_wd, mk_rd;

    logic accept, ok, diag, better;
    logic [15:0] c_lat, c_hop, age_lat, s_hop;
    logic [1:0] mark_n;

    tapu_ram #(.DW(32), .AW(CELL_BITS)) u_comm (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_wa), .i_wdata(cm_wd),
        .i_re(cm_re), .i_raddr(cm_ra), .o_rdata(cm_rd)
    );
    tapu_ram #(.DW(32), .AW(CELL_BITS)) u_work (
        .i_clk(i_clk), .i_we(wk_we), .i_waddr(wk_wa), .i_wdata(wk_wd),
        .i_re(wk_re), .i_raddr(wk_ra), .o_rdata(wk_rd)
    );
    tapu_ram #(.DW(2), .AW(CELL_BITS)) u_mark (
        .i_clk(i_clk), .i_we(mk_we), .i_waddr(mk_wa), .i_wdata(mk_wd),
        .i_re(mk_re), .i_raddr(mk_ra), .o_rdata(mk_rd)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;
    assign accept = i_in_valid && (r_state == S_IDLE);
    assign ok = (i_in_data.first_node != '0) && (i_in_data.second_node != '0);

    always_comb begin
        diag = (r_p_addr[CELL_BITS-1:NODE_BITS] == r_p_addr[NODE_BITS-1:0]);
        c_lat = (r_commit && !diag) ? wk_rd[31:16] : cm_rd[31:16];
        c_hop = (r_commit && !diag) ? wk_rd[15:0] : cm_rd[15:0];
        if (!r_commit) begin
            mark_n = mk_rd;
        end else if (!diag && c_lat != NO_PATH) begin
            mark_n = MARK_REACH;
        end else if (mk_rd == MARK_REACH) begin
            mark_n = MARK_REACH;
        end else begin
            mark_n = MARK_NONE;
        end
        age_lat = (c_lat == NO_PATH) ? NO_PATH : sat_add(c_lat, r_delay);
        s_hop = sat_add(cm_rd[15:0], 16'd1);
        better = (cm_rd[31:16] != NO_PATH) && (r_p_addr[NODE_BITS-1:0] != r_row) &&
                 ((cm_rd[31:16] < wk_rd[31:16]) ||
                  ((cm_rd[31:16] == wk_rd[31:16]) && (s_hop < wk_rd[15:0])));
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_p_vld = 1'b0;
        n_p_addr = r_p_addr;
        n_open = r_open;
        n_commit = r_commit;
        n_cur = r_cur;
        n_inst = r_inst;
        n_delay = r_delay;
        n_row = r_row;
        n_via = r_via;
        n_pass = r_pass;
        n_rd_ok = r_rd_ok;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        cm_we = 1'b0; wk_we = 1'b0; mk_we = 1'b0;
        cm_re = 1'b0; wk_re = 1'b0; mk_re = 1'b0;
        cm_wa = r_p_addr; wk_wa = r_p_addr; mk_wa = r_p_addr;
        cm_ra = r_cnt; wk_ra = r_cnt; mk_ra = r_cnt;
        cm_wd = {age_lat, c_hop};
        wk_wd = {age_lat, c_hop};
        mk_wd = mark_n;

        if (r_p_vld && (r_state == S_SWEEP || r_state == S_SWEEP_END)) begin
            cm_we = 1'b1;
            wk_we = 1'b1;
            mk_we = 1'b1;
        end
        if (r_p_vld && (r_state == S_WALK || r_state == S_DRAIN) && better) begin
            wk_we = 1'b1;
            wk_wd = {cm_rd[31:16], s_hop};
            mk_we = 1'b1;
            mk_wd = MARK_CHG;
        end

        case (r_state)
            S_CLEAR: begin
                cm_we = 1'b1; wk_we = 1'b1; mk_we = 1'b1;
                cm_wa = r_cnt; wk_wa = r_cnt; mk_wa = r_cnt;
                cm_wd = {NO_PATH, NO_PATH};
                wk_wd = {NO_PATH, NO_PATH};
                mk_wd = MARK_NONE;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_row = i_in_data.second_node;
                    n_via = i_in_data.first_node;
                    n_inst = i_in_data.instant;
                    n_pass = 1'b0;
                    if (i_in_data.opcode == OP_READ) begin
                        n_rd_ok = ok;
                        wk_re = ok;
                        mk_re = ok;
                        wk_ra = {i_in_data.first_node, i_in_data.second_node};
                        mk_ra = {i_in_data.first_node, i_in_data.second_node};
                        n_state = S_OUT;
                    end else if (ok) begin
                        if (!r_open || i_in_data.instant > r_cur) begin
                            n_commit = r_open;
                            n_delay = i_in_data.instant - r_cur;
                            n_cnt = '0;
                            n_state = S_SWEEP;
                        end else begin
                            n_state = S_DIRECT;
                        end
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_rd_ok) begin
                        n_out.latency = wk_rd[31:16];
                        n_out.hop_count = wk_rd[15:0];
                        n_out.changed_now = (mk_rd == MARK_CHG);
                    end else begin
                        n_out.latency = NO_PATH;
                        n_out.hop_count = NO_PATH;
                        n_out.changed_now = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                cm_re = 1'b1; wk_re = 1'b1; mk_re = 1'b1;
                n_p_vld = 1'b1;
                n_p_addr = r_cnt;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_SWEEP_END;
                end
            end
            S_SWEEP_END: begin
                n_cur = r_inst;
                n_open = 1'b1;
                n_state = S_DIRECT;
            end
            S_DIRECT: begin
                wk_we = 1'b1; mk_we = 1'b1;
                wk_wa = {r_row, r_via};
                mk_wa = {r_row, r_via};
                wk_wd = {16'd1, 16'd1};
                mk_wd = MARK_CHG;
                n_cnt = {{NODE_BITS{1'b0}}, {(NODE_BITS-1){1'b0}}, 1'b1};
                n_state = S_WALK;
            end
            S_WALK: begin
                cm_re = 1'b1; wk_re = 1'b1;
                cm_ra = {r_via, r_cnt[NODE_BITS-1:0]};
                wk_ra = {r_row, r_cnt[NODE_BITS-1:0]};
                n_p_vld = 1'b1;
                n_p_addr = {r_row, r_cnt[NODE_BITS-1:0]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[NODE_BITS-1:0] == '1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_pass && r_undir) begin
                    n_pass = 1'b1;
                    n_row = r_via;
                    n_via = r_row;
                    n_state = S_DIRECT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= '0;
            r_p_vld <= 1'b0;
            r_undir <= 1'b1;
            r_open <= 1'b0;
            r_commit <= 1'b0;
            r_cur <= '0;
            r_pass <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_p_vld <= n_p_vld;
            if (i_cfg_we) begin
                r_undir <= i_cfg_wdata;
            end
            r_open <= n_open;
            r_commit <= n_commit;
            r_cur <= n_cur;
            r_pass <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_addr <= n_p_addr;
        r_inst <= n_inst;
        r_delay <= n_delay;
        r_row <= n_row;
        r_via <= n_via;
        r_rd_ok <= n_rd_ok;
        r_out <= n_out;
    end

endmodule
`default_nettype wire
